/* hdl/bmm_pkg.sv */
// shared constants, codes and types of the batched matrix multiply block
`timescale 1ns / 1ps
package bmm_pkg;

	// default sizes
	localparam int MAX_PHYS_DEF  = 4;
	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 16;

	// field widths
	localparam int CMD_W    = 2;
	localparam int PHYS_W   = 2;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	// configuration register widths
	localparam int PCNT_W   = 3;
	localparam int DIM_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 4;

	// exact sum of up to fifteen 64-bit products
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + DIM_W;

	// commands
	localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RD   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DIM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DIM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARED_B   = 3'd4;

	// configuration reset values
	localparam logic [PCNT_W-1:0] PCNT_RST = 3'd1;
	localparam logic [DIM_W-1:0]  DIM_RST  = 4'd8;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctrl_t;

	// status from the multiply-accumulate unit
	typedef struct packed {
		logic              busy;
		logic              sat;
		logic [DATA_W-1:0] product;
	} mac_stat_t;

endpackage

/* hdl/bmm_in_if.sv */
// request channel of the batched matrix multiply block
`timescale 1ns / 1ps
interface bmm_in_if;
	logic                        valid;
	logic                        ready;
	logic [bmm_pkg::CMD_W-1:0]   cmd;
	logic [bmm_pkg::PHYS_W-1:0]  phys;
	logic [bmm_pkg::IDX_W-1:0]   row;
	logic [bmm_pkg::IDX_W-1:0]   col;
	logic signed [bmm_pkg::DATA_W-1:0] value;

	modport source (output valid, cmd, phys, row, col, value, input ready);
	modport sink (input valid, cmd, phys, row, col, value, output ready);
endinterface

/* hdl/bmm_out_if.sv */
// result channel of the batched matrix multiply block
`timescale 1ns / 1ps
interface bmm_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [bmm_pkg::DATA_W-1:0]  product;
	logic [bmm_pkg::STATUS_W-1:0]       status;

	modport source (output valid, product, status, input ready);
	modport sink (input valid, product, status, output ready);
endinterface

/* hdl/bmm_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module bmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bmm_mac.sv */
// multiply-accumulate unit: registered product, wide accumulator, final shift and saturate
`timescale 1ns / 1ps
module bmm_mac #(
	parameter int FRAC_BITS = bmm_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bmm_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [bmm_pkg::DATA_W-1:0]   a_data,
	input  logic signed [bmm_pkg::DATA_W-1:0]   b_data,
	output bmm_pkg::mac_stat_t                  stat
);

	logic                                 rd_s1;
	logic                                 mul_s2;
	logic signed [bmm_pkg::PROD_W-1:0]    prod_s2;
	logic signed [bmm_pkg::ACC_W-1:0]     acc_q;
	logic signed [bmm_pkg::PROD_W-1:0]    prod;
	logic signed [bmm_pkg::ACC_W-1:0]     shifted;
	logic                                 fits;
	logic                                 neg;

	assign prod = a_data * b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1  <= 1'b0;
			mul_s2 <= 1'b0;
		end else begin
			rd_s1  <= ctrl.issue;
			mul_s2 <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			prod_s2 <= prod;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (mul_s2) begin
			acc_q <= acc_q + bmm_pkg::ACC_W'(prod_s2);
		end
	end

	// arithmetic shift rounds toward minus infinity
	assign shifted = acc_q >>> FRAC_BITS;
	assign neg     = shifted[bmm_pkg::ACC_W-1];
	assign fits    = (&shifted[bmm_pkg::ACC_W-1:bmm_pkg::DATA_W-1])
		|| ~(|shifted[bmm_pkg::ACC_W-1:bmm_pkg::DATA_W-1]);

	always_comb begin
		stat.busy = rd_s1 | mul_s2;
		stat.sat  = ~fits;
		if (fits) begin
			stat.product = shifted[bmm_pkg::DATA_W-1:0];
		end else if (neg) begin
			stat.product = {1'b1, {(bmm_pkg::DATA_W-1){1'b0}}};
		end else begin
			stat.product = {1'b0, {(bmm_pkg::DATA_W-1){1'b1}}};
		end
	end

endmodule

/* hdl/batched_matrix_multiply_core.sv */
// top level of the batched matrix multiply block
// usage:
// - config port: cfg_we, cfg_index, cfg_data write phys_count, left_dim, inner_dim,
//   right_dim and shared_b; write only while the block is idle
// - req channel (valid/ready): a request writes an entry of A or B, or reads one
//   entry of C = A[p] * B[p] (B[0] for every p when shared_b is set)
// - rsp channel (valid/ready): one response per read request, none for writes
// - a write request keeps the block idle; invalid writes are dropped silently
// - a read request in range holds req.ready low until its response is loaded;
//   the dot product runs one multiply-accumulate per cycle, bound by the single
//   read port of each store, through a store read stage and a product register,
//   and the shifted, saturated sum is taken into the output register
// - an out-of-range read answers product 0, status 1
// - reset clears control and configuration (phys_count 1, dims 8, shared_b 0);
//   the stores are not cleared and must be written before they are read
// - a stalled response is held in the output register; further writes are still
//   taken, and a read finishes and waits there until the response slot frees up
`timescale 1ns / 1ps
module batched_matrix_multiply_core #(
	parameter int MAX_PHYS  = bmm_pkg::MAX_PHYS_DEF,
	parameter int MAX_DIM   = bmm_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = bmm_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	bmm_in_if.sink                           req,
	bmm_out_if.source                        rsp
);

	localparam int DEPTH  = MAX_PHYS * MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		WRAP
	} state_t;

	function automatic logic [ADDR_W-1:0] slot(
		input logic [bmm_pkg::PHYS_W-1:0] p,
		input logic [bmm_pkg::DIM_W-1:0]  r,
		input logic [bmm_pkg::DIM_W-1:0]  c
	);
		logic [31:0] s;
		s = 32'(p) * 32'(MAX_DIM * MAX_DIM) + 32'(r) * 32'(MAX_DIM) + 32'(c);
		return s[ADDR_W-1:0];
	endfunction

	// configuration
	logic [bmm_pkg::PCNT_W-1:0] phys_count_q;
	logic [bmm_pkg::DIM_W-1:0]  left_dim_q;
	logic [bmm_pkg::DIM_W-1:0]  inner_dim_q;
	logic [bmm_pkg::DIM_W-1:0]  right_dim_q;
	logic                       shared_b_q;

	// sequencer
	state_t                       state_q;
	logic [bmm_pkg::PHYS_W-1:0]   p_q;
	logic [bmm_pkg::PHYS_W-1:0]   q_q;
	logic [bmm_pkg::DIM_W-1:0]    r_q;
	logic [bmm_pkg::DIM_W-1:0]    c_q;
	logic [bmm_pkg::DIM_W-1:0]    k_q;
	logic [bmm_pkg::DIM_W-1:0]    ni_q;
	logic                         oor_q;

	// output register
	logic                         out_valid_q;
	logic [bmm_pkg::DATA_W-1:0]   product_q;
	logic [bmm_pkg::STATUS_W-1:0] status_q;

	logic                         accept;
	logic [bmm_pkg::DIM_W-1:0]    row_w;
	logic [bmm_pkg::DIM_W-1:0]    col_w;
	logic                         phys_ok;
	logic                         row_l_ok;
	logic                         row_i_ok;
	logic                         col_i_ok;
	logic                         col_r_ok;
	logic [bmm_pkg::DIM_W-1:0]    ni;
	logic                         last_k;
	logic                         out_free;
	logic                         load_out;
	logic                         a_we;
	logic                         b_we;
	logic [ADDR_W-1:0]            waddr;
	logic [ADDR_W-1:0]            a_raddr;
	logic [ADDR_W-1:0]            b_raddr;
	logic [bmm_pkg::DATA_W-1:0]   a_rdata;
	logic [bmm_pkg::DATA_W-1:0]   b_rdata;
	bmm_pkg::mac_ctrl_t           mac_ctrl;
	bmm_pkg::mac_stat_t           mac_stat;

	assign req.ready = (state_q == IDLE);
	assign accept    = req.valid & req.ready;

	assign row_w = bmm_pkg::DIM_W'(req.row);
	assign col_w = bmm_pkg::DIM_W'(req.col);

	// register values above the maximum act as the maximum
	assign phys_ok  = (bmm_pkg::PCNT_W'(req.phys) < phys_count_q)
		&& (32'(req.phys) < 32'(MAX_PHYS));
	assign row_l_ok = (row_w < left_dim_q) && (32'(req.row) < 32'(MAX_DIM));
	assign row_i_ok = (row_w < inner_dim_q) && (32'(req.row) < 32'(MAX_DIM));
	assign col_i_ok = (col_w < inner_dim_q) && (32'(req.col) < 32'(MAX_DIM));
	assign col_r_ok = (col_w < right_dim_q) && (32'(req.col) < 32'(MAX_DIM));
	assign ni = (32'(inner_dim_q) > 32'(MAX_DIM)) ? bmm_pkg::DIM_W'(MAX_DIM) : inner_dim_q;

	assign a_we  = accept && (req.cmd == bmm_pkg::CMD_WR_A) && phys_ok && row_l_ok && col_i_ok;
	assign b_we  = accept && (req.cmd == bmm_pkg::CMD_WR_B) && phys_ok && row_i_ok && col_r_ok;
	assign waddr = slot(req.phys, row_w, col_w);

	assign a_raddr = slot(p_q, r_q, k_q);
	assign b_raddr = slot(q_q, k_q, c_q);
	assign last_k  = ((bmm_pkg::DIM_W + 1)'(k_q) + 1'b1) == (bmm_pkg::DIM_W + 1)'(ni_q);

	assign out_free = ~out_valid_q | rsp.ready;
	assign load_out = (state_q == WRAP) && !mac_stat.busy && out_free;

	assign mac_ctrl.clear = accept && (req.cmd == bmm_pkg::CMD_RD);
	assign mac_ctrl.issue = (state_q == RUN);

	bmm_ram #(
		.WIDTH (bmm_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (req.value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	bmm_ram #(
		.WIDTH (bmm_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (req.value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	bmm_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a_data (a_rdata),
		.b_data (b_rdata),
		.stat   (mac_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_count_q <= bmm_pkg::PCNT_RST;
			left_dim_q   <= bmm_pkg::DIM_RST;
			inner_dim_q  <= bmm_pkg::DIM_RST;
			right_dim_q  <= bmm_pkg::DIM_RST;
			shared_b_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmm_pkg::CFG_PHYS_COUNT: phys_count_q <= cfg_data[bmm_pkg::PCNT_W-1:0];
				bmm_pkg::CFG_LEFT_DIM:   left_dim_q   <= cfg_data[bmm_pkg::DIM_W-1:0];
				bmm_pkg::CFG_INNER_DIM:  inner_dim_q  <= cfg_data[bmm_pkg::DIM_W-1:0];
				bmm_pkg::CFG_RIGHT_DIM:  right_dim_q  <= cfg_data[bmm_pkg::DIM_W-1:0];
				bmm_pkg::CFG_SHARED_B:   shared_b_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			oor_q       <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept && (req.cmd == bmm_pkg::CMD_RD)) begin
						oor_q <= ~(phys_ok && row_l_ok && col_r_ok);
						k_q   <= '0;
						// an empty dot product goes straight to the result
						if (phys_ok && row_l_ok && col_r_ok && (ni != '0)) begin
							state_q <= RUN;
						end else begin
							state_q <= WRAP;
						end
					end
				end
				RUN: begin
					k_q <= k_q + 1'b1;
					if (last_k) begin
						state_q <= WRAP;
					end
				end
				WRAP: begin
					if (load_out) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.cmd == bmm_pkg::CMD_RD)) begin
			p_q  <= req.phys;
			q_q  <= shared_b_q ? '0 : req.phys;
			r_q  <= row_w;
			c_q  <= col_w;
			ni_q <= ni;
		end
		if (load_out) begin
			if (oor_q) begin
				product_q <= '0;
				status_q  <= bmm_pkg::ST_RANGE;
			end else begin
				product_q <= mac_stat.product;
				status_q  <= mac_stat.sat ? bmm_pkg::ST_SAT : bmm_pkg::ST_OK;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.product = product_q;
	assign rsp.status  = status_q;

endmodule
